// ===== rtl/sfcc_pkg.sv =====
// Package for the sensor frame CRC check and convert block.
// Holds status codes, frame constants, the result type and the CRC-8 step.
// No dependencies.
package sfcc_pkg;

  localparam int FrameStored = 5;           // bytes held before the closing CRC byte
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_TEMP_CRC = 2'd2;
  localparam logic [1:0] ST_HUM_CRC  = 2'd3;

  localparam logic signed [7:0] TempError = -8'sd128;
  localparam logic [7:0]        HumError  = 8'hFF;
  localparam logic signed [7:0] TempMax   = 8'sd127;

  // Temperature: (350*raw - 5832615) / 131070, truncated toward zero
  localparam logic [25:0] TempOffset = 26'd5832615;
  // Humidity: (200*raw + 65535) / 131070, truncated
  localparam logic [23:0] HumRound   = 24'd65535;

  typedef struct packed {
    logic [1:0]        status;
    logic [15:0]       raw_humidity;
    logic [15:0]       raw_temperature;
    logic [7:0]        humidity_pct;
    logic signed [7:0] temperature_c;
  } result_t;

  // One byte through the CRC-8, MSB first, no reflection
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] crc8_word(input logic [7:0] hi, input logic [7:0] lo);
    return crc8_byte(crc8_byte(CrcInit, hi), lo);
  endfunction

endpackage

// ===== rtl/sensor_frame_crc_check_and_convert.sv =====
// Sensor frame CRC check and convert, top level.
// Uses sfcc_pkg for codes, the result type and the CRC-8 functions.
//
// Usage:
//   Input channel s_*: one item per received byte. s_tuser[0] = 0 carries a
//   frame byte in s_tdata, s_tuser[0] = 1 marks an early end of transfer.
//   A frame is six bytes: temperature word (MSB first), its CRC-8, humidity
//   word, its CRC-8. Bytes one to five only update internal storage.
//   Output channel m_*: one item per completed frame or early end, with the
//   status in m_tuser and both converted values plus both raw words in m_tdata.
// Latency: when the output is free, the result of the sixth byte or of an early end
//   is on m_* in the cycle after the input item is accepted; else it waits in skid.
// Throughput: one input item per cycle unless stalled. The CRC checks and both
//   scalings are constant-coefficient logic between byte store and result register.
// Stall: the result register is backed by one skid entry, so an item is taken
//   while a result waits; s_tready drops only when the skid entry is full.
// Reset: rst clears the byte count and both valid flags; stored frame bytes
//   keep stale contents and are always rewritten before use.
module sensor_frame_crc_check_and_convert (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] temperature_c, [15:8] humidity_pct,
                                 // [31:16] raw_temperature, [47:32] raw_humidity
  output logic [1:0]  m_tuser    // [1:0] status
);

  logic [7:0]           frame_bytes [sfcc_pkg::FrameStored];
  logic [2:0]           byte_count;
  logic                 skid_valid;
  sfcc_pkg::result_t    out_res;
  sfcc_pkg::result_t    skid_res;
  sfcc_pkg::result_t    res_next;

  logic        accept;
  logic        last_byte;
  logic        res_valid;
  logic        out_free;

  logic [15:0] raw_t;
  logic [15:0] raw_h;
  logic        crc_t_ok;
  logic        crc_h_ok;

  // temperature path
  logic [24:0] t_prod;
  logic [25:0] t_num;
  logic        t_neg;
  logic [24:0] t_mag;
  logic [23:0] t_half;
  logic [24:0] t_sum;
  logic [8:0]  t_quot;
  logic signed [7:0] t_val;

  // humidity path
  logic [23:0] h_num;
  logic [22:0] h_half;
  logic [23:0] h_sum;
  logic [7:0]  h_val;

  assign s_tready  = !skid_valid;
  assign accept    = s_tvalid && s_tready;
  assign last_byte = (byte_count >= 3'(sfcc_pkg::FrameStored));
  assign res_valid = accept && (s_tuser[0] || last_byte);
  assign out_free  = !m_tvalid || m_tready;

  assign raw_t = {frame_bytes[0], frame_bytes[1]};
  assign raw_h = {frame_bytes[3], frame_bytes[4]};

  assign crc_t_ok = (sfcc_pkg::crc8_word(frame_bytes[0], frame_bytes[1]) == frame_bytes[2]);
  assign crc_h_ok = (sfcc_pkg::crc8_word(frame_bytes[3], frame_bytes[4]) == s_tdata);

  // Division by 131070: halve, then divide by 2^16-1 as (x + (x >> 16) + 1) >> 16,
  // exact for quotients below 2^16.
  always_comb begin
    t_prod = 25'(raw_t) * 25'd350;
    t_num  = {1'b0, t_prod} - sfcc_pkg::TempOffset;
    t_neg  = t_num[25];
    t_mag  = t_neg ? 25'(-t_num) : t_num[24:0];
    t_half = t_mag[24:1];
    t_sum  = 25'(t_half) + 25'(t_half[23:16]) + 25'd1;
    t_quot = t_sum[24:16];
    if (t_neg) begin
      t_val = -$signed(t_quot[7:0]);          // magnitude stays below 45
    end else if (t_quot > 9'd127) begin
      t_val = sfcc_pkg::TempMax;
    end else begin
      t_val = $signed(t_quot[7:0]);
    end

    h_num  = 24'(raw_h) * 24'd200 + sfcc_pkg::HumRound;
    h_half = h_num[23:1];
    h_sum  = 24'(h_half) + 24'(h_half[22:16]) + 24'd1;
    h_val  = h_sum[23:16];
  end

  always_comb begin
    res_next.status          = sfcc_pkg::ST_OK;
    res_next.temperature_c   = t_val;
    res_next.humidity_pct    = h_val;
    res_next.raw_temperature = raw_t;
    res_next.raw_humidity    = raw_h;
    if (s_tuser[0]) begin
      res_next.status          = sfcc_pkg::ST_SHORT;
      res_next.temperature_c   = sfcc_pkg::TempError;
      res_next.humidity_pct    = sfcc_pkg::HumError;
      res_next.raw_temperature = '0;
      res_next.raw_humidity    = '0;
    end else if (!crc_t_ok) begin
      res_next.status        = sfcc_pkg::ST_TEMP_CRC;
      res_next.temperature_c = sfcc_pkg::TempError;
      res_next.humidity_pct  = sfcc_pkg::HumError;
    end else if (!crc_h_ok) begin
      res_next.status        = sfcc_pkg::ST_HUM_CRC;
      res_next.temperature_c = sfcc_pkg::TempError;
      res_next.humidity_pct  = sfcc_pkg::HumError;
    end
  end

  // Control: byte count, result and skid valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (s_tuser[0] || last_byte) begin
          byte_count <= '0;
        end else begin
          byte_count <= byte_count + 3'd1;
        end
      end
      if (out_free) begin
        if (skid_valid) begin
          m_tvalid   <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          m_tvalid <= res_valid;
        end
      end else if (res_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload: frame store, result register, skid entry
  always_ff @(posedge clk) begin
    if (accept && !s_tuser[0] && !last_byte) begin
      frame_bytes[byte_count] <= s_tdata;
    end
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (res_valid) begin
        out_res <= res_next;
      end
    end else if (res_valid) begin
      skid_res <= res_next;
    end
  end

  assign m_tuser = out_res.status;
  assign m_tdata = {out_res.raw_humidity, out_res.raw_temperature,
                    out_res.humidity_pct, out_res.temperature_c};

`ifndef SYNTHESIS
  // skid entry is only filled behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid) else $error("skid entry valid without output valid");

  // byte count never passes FrameStored, its value at the closing CRC byte
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= 3'(sfcc_pkg::FrameStored)) else $error("byte count out of range");

  // good frame gives humidity within 0..100
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == sfcc_pkg::ST_OK) |-> (m_tdata[15:8] <= 8'd100))
    else $error("humidity out of range on good frame");

  // any error status carries the error values
  a_err_values: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != sfcc_pkg::ST_OK) |->
      (m_tdata[7:0] == sfcc_pkg::TempError && m_tdata[15:8] == sfcc_pkg::HumError))
    else $error("error result without error values");

  // early end with a free output shows up next cycle as a short-frame result
  a_short_result: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser[0] && out_free) |=> (m_tvalid && m_tuser == sfcc_pkg::ST_SHORT))
    else $error("early end did not produce a short-frame result");
`endif

endmodule
